### hw/rtl/iptp_pkg.sv
// Shared constants, command and status types and helpers of the address text parser.
`default_nettype none

package iptp_pkg;

  // ASCII codes that steer the parse
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // Address shape
  localparam int unsigned V4_OCTETS     = 4;
  localparam int unsigned V4_MAX_DIGITS = 3;
  localparam int unsigned V6_GROUPS     = 8;
  localparam int unsigned V6_HEX_DIGITS = 4;
  localparam logic [9:0]  OCTET_MAX     = 10'd255;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;    // accept one character
    logic flush;   // store the last open IPv6 group
    logic insert;  // open one zero group at the double-colon gap
    logic emit;    // load the result register and clear the parse state
  } iptp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_term;      // current character is the terminator
    logic expand_done;  // no further zero groups to insert
  } iptp_sts_t;

  // Hex digit decode: bit 4 marks a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
        r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
        r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
        r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ip_address_text_parser_unit.sv
// Top level of the IPv4/IPv6 address text parser.
//
// Input channel: one ASCII character per transaction on character, with
// char_valid/char_stall. A zero character ends the address string.
// Output channel: one result per string on status, version, addr_high and
// addr_low, with result_valid/result_stall. Only the terminator yields a
// result; every other character yields none.
// Throughput: one character per cycle while a string is being read.
// After the terminator is taken the input stalls for the group store, one
// opening of a zero group for each slot that the double colon leaves (at
// most 8), a check of the gap and the result load; the group store is widened
// one slot a cycle.
// A result waiting in the output register does not block the next string:
// characters are taken while result_stall is high, and only the next
// result load waits for the register to be free.
// Reset (rst, synchronous) clears the parse state and drops result_valid.
`default_nettype none

module ip_address_text_parser_unit
  import iptp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire logic [7:0] character,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic            status,
  output logic            version,
  output logic [63:0]     addr_high,
  output logic [63:0]     addr_low
);

  iptp_cmd_t cmd;
  iptp_sts_t sts;

  // Sequence the parse
  iptp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Parse state and result
  iptp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .character (character),
    .sts       (sts),
    .status    (status),
    .version   (version),
    .addr_high (addr_high),
    .addr_low  (addr_low)
  );

endmodule

`default_nettype wire

### hw/rtl/iptp_ctrl.sv
// Controller: sequences character intake, final group store, gap expansion and result hand-off.
`default_nettype none

module iptp_ctrl
  import iptp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      char_valid,
  output logic           char_stall,
  output logic           result_valid,
  input  wire logic      result_stall,
  input  wire iptp_sts_t sts,
  output iptp_cmd_t      cmd
);

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_FLUSH  = 2'd1;
  localparam logic [1:0] ST_EXPAND = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       result_valid_next;
  logic       char_acc;
  logic       out_free;

  // Accept characters only in the run state
  assign char_stall = (state != ST_RUN);
  assign char_acc   = char_valid && !char_stall;
  assign out_free   = !result_valid || !result_stall;

  // Drive datapath commands
  always_comb begin
    cmd        = '0;
    cmd.step   = char_acc;
    cmd.flush  = (state == ST_FLUSH);
    cmd.insert = (state == ST_EXPAND) && !sts.expand_done;
    cmd.emit   = (state == ST_EMIT) && out_free;
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (char_acc && sts.is_term) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ST_EXPAND;
      end
      ST_EXPAND: begin
        if (sts.expand_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Hold the result until the transaction completes
  always_comb begin
    result_valid_next = result_valid;
    if (cmd.emit) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/iptp_datapath.sv
// Datapath: IPv4 and IPv6 parse state, group store, gap expansion and result register.
`default_nettype none

module iptp_datapath
  import iptp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire iptp_cmd_t  cmd,
  input  wire logic [7:0] character,
  output iptp_sts_t       sts,
  output logic            status,
  output logic            version,
  output logic [63:0]     addr_high,
  output logic [63:0]     addr_low
);

  // Shared state
  logic        colon_seen;
  logic        colon_seen_next;

  // IPv4 state
  logic [9:0]  v4_octet_value;
  logic [9:0]  v4_octet_value_next;
  logic [1:0]  v4_digit_count;
  logic [1:0]  v4_digit_count_next;
  logic [2:0]  v4_octet_count;
  logic [2:0]  v4_octet_count_next;
  logic [31:0] v4_octets;
  logic [31:0] v4_octets_next;
  logic        v4_failed;
  logic        v4_failed_next;

  // IPv6 state
  logic [15:0] v6_groups [V6_GROUPS];
  logic [3:0]  v6_group_index;
  logic [3:0]  v6_group_index_next;
  logic [15:0] v6_hex_value;
  logic [15:0] v6_hex_value_next;
  logic [2:0]  v6_hex_count;
  logic [2:0]  v6_hex_count_next;
  logic        v6_gap_found;
  logic        v6_gap_found_next;
  logic [3:0]  v6_gap_position;
  logic [3:0]  v6_gap_position_next;
  logic        v6_colon_pending;
  logic        v6_colon_pending_next;
  logic        v6_stopped;
  logic        v6_stopped_next;
  logic        v6_failed;
  logic        v6_failed_next;
  logic        grp_we;

  logic        is_digit;
  logic [3:0]  dec_digit;
  logic [4:0]  nib;
  logic        v6_live;
  logic        store_ok;
  logic        last_group;

  logic [127:0] v6_flat;

  assign is_digit  = (character inside {[CHR_ZERO:CHR_NINE]});
  assign dec_digit = 4'(character - CHR_ZERO);
  assign nib       = hex_nibble(character);
  assign v6_live   = !v6_stopped && !v6_failed;
  assign store_ok  = (v6_hex_count != 3'd0) && (v6_group_index < 4'(V6_GROUPS));
  assign last_group = (v6_group_index == 4'(V6_GROUPS - 1));

  assign sts.is_term     = (character == CHR_NUL);
  assign sts.expand_done = !(colon_seen && !v6_failed && v6_gap_found &&
                             (v6_group_index < 4'(V6_GROUPS)));

  // IPv4 parse: dotted decimal octets
  always_comb begin
    v4_octet_value_next = v4_octet_value;
    v4_digit_count_next = v4_digit_count;
    v4_octet_count_next = v4_octet_count;
    v4_octets_next      = v4_octets;
    v4_failed_next      = v4_failed;
    if (cmd.step && !v4_failed) begin
      if (character == CHR_NUL || character == CHR_DOT) begin
        if (v4_digit_count == 2'd0 || v4_octet_value > OCTET_MAX ||
            v4_octet_count >= 3'(V4_OCTETS)) begin
          v4_failed_next = 1'b1;
        end else begin
          v4_octets_next      = {v4_octets[23:0], v4_octet_value[7:0]};
          v4_octet_count_next = v4_octet_count + 3'd1;
          v4_octet_value_next = '0;
          v4_digit_count_next = '0;
        end
        if (character == CHR_NUL && !v4_failed_next &&
            v4_octet_count_next != 3'(V4_OCTETS)) begin
          v4_failed_next = 1'b1;
        end
      end else if (is_digit) begin
        if (v4_digit_count >= 2'(V4_MAX_DIGITS)) begin
          v4_failed_next = 1'b1;
        end else begin
          v4_octet_value_next = 10'({3'b000, v4_octet_value} * 13'd10 + 13'(dec_digit));
          v4_digit_count_next = v4_digit_count + 2'd1;
        end
      end else begin
        v4_failed_next = 1'b1;
      end
    end
  end

  // IPv6 parse: hex groups, colons and the double-colon gap
  always_comb begin
    v6_group_index_next   = v6_group_index;
    v6_hex_value_next     = v6_hex_value;
    v6_hex_count_next     = v6_hex_count;
    v6_gap_found_next     = v6_gap_found;
    v6_gap_position_next  = v6_gap_position;
    v6_colon_pending_next = v6_colon_pending;
    v6_stopped_next       = v6_stopped;
    v6_failed_next        = v6_failed;
    grp_we                = 1'b0;
    colon_seen_next       = colon_seen;
    if (cmd.step && character == CHR_COLON) colon_seen_next = 1'b1;

    if (cmd.step && character != CHR_NUL && v6_live) begin
      if (character == CHR_COLON) begin
        if (v6_colon_pending) begin
          if (store_ok) begin
            grp_we              = 1'b1;
            v6_group_index_next = v6_group_index + 4'd1;
            v6_hex_value_next   = '0;
            v6_hex_count_next   = '0;
            v6_stopped_next     = last_group;
          end
          if (!v6_gap_found) begin
            v6_gap_found_next     = 1'b1;
            v6_gap_position_next  = v6_group_index_next;
            v6_colon_pending_next = 1'b0;
          end
        end else begin
          v6_colon_pending_next = 1'b1;
        end
      end else begin
        if (v6_colon_pending) begin
          v6_colon_pending_next = 1'b0;
          if (store_ok) begin
            grp_we              = 1'b1;
            v6_group_index_next = v6_group_index + 4'd1;
            v6_hex_value_next   = '0;
            v6_hex_count_next   = '0;
            v6_stopped_next     = last_group;
          end
        end
        // Drop the character once the eighth group has just been stored
        if (!v6_stopped_next) begin
          if (!nib[4]) begin
            v6_failed_next = 1'b1;
          end else if (v6_hex_count_next < 3'(V6_HEX_DIGITS)) begin
            v6_hex_value_next = {v6_hex_value_next[11:0], nib[3:0]};
            v6_hex_count_next = v6_hex_count_next + 3'd1;
          end
        end
      end
    end else if (cmd.flush && v6_live) begin
      // Store the group still open at the terminator
      v6_colon_pending_next = 1'b0;
      if (store_ok) begin
        grp_we              = 1'b1;
        v6_group_index_next = v6_group_index + 4'd1;
        v6_hex_value_next   = '0;
        v6_hex_count_next   = '0;
        v6_stopped_next     = last_group;
      end
    end else if (cmd.insert) begin
      v6_group_index_next = v6_group_index + 4'd1;
    end
  end

  // Group store: write one group, or open a zero group at the gap
  always_ff @(posedge clk) begin
    if (grp_we) begin
      v6_groups[v6_group_index[2:0]] <= v6_hex_value;
    end else if (cmd.insert) begin
      for (int k = 0; k < V6_GROUPS; k++) begin
        if (4'(k) == v6_gap_position) begin
          v6_groups[3'(k)] <= '0;
        end else if (4'(k) > v6_gap_position) begin
          v6_groups[3'(k)] <= v6_groups[3'(k - 1)];
        end
      end
    end
  end

  // Flatten groups, masking slots that were never stored
  always_comb begin
    v6_flat = '0;
    for (int k = 0; k < V6_GROUPS; k++) begin
      if (4'(k) < v6_group_index) begin
        v6_flat[127 - 16*k -: 16] = v6_groups[3'(k)];
      end
    end
  end

  // Parse state registers; clear after each result
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      colon_seen       <= 1'b0;
      v4_octet_value   <= '0;
      v4_digit_count   <= '0;
      v4_octet_count   <= '0;
      v4_octets        <= '0;
      v4_failed        <= 1'b0;
      v6_group_index   <= '0;
      v6_hex_value     <= '0;
      v6_hex_count     <= '0;
      v6_gap_found     <= 1'b0;
      v6_gap_position  <= '0;
      v6_colon_pending <= 1'b0;
      v6_stopped       <= 1'b0;
      v6_failed        <= 1'b0;
    end else begin
      colon_seen       <= colon_seen_next;
      v4_octet_value   <= v4_octet_value_next;
      v4_digit_count   <= v4_digit_count_next;
      v4_octet_count   <= v4_octet_count_next;
      v4_octets        <= v4_octets_next;
      v4_failed        <= v4_failed_next;
      v6_group_index   <= v6_group_index_next;
      v6_hex_value     <= v6_hex_value_next;
      v6_hex_count     <= v6_hex_count_next;
      v6_gap_found     <= v6_gap_found_next;
      v6_gap_position  <= v6_gap_position_next;
      v6_colon_pending <= v6_colon_pending_next;
      v6_stopped       <= v6_stopped_next;
      v6_failed        <= v6_failed_next;
    end
  end

  // Result register: pick the parse by the colon flag
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      version <= colon_seen;
      if (colon_seen) begin
        status    <= v6_failed;
        addr_high <= v6_failed ? 64'd0 : v6_flat[127:64];
        addr_low  <= v6_failed ? 64'd0 : v6_flat[63:0];
      end else begin
        status    <= v4_failed;
        addr_high <= 64'd0;
        addr_low  <= v4_failed ? 64'd0 : {32'd0, v4_octets};
      end
    end
  end

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the IPv4/IPv6 address text parser.
`default_nettype none

module tb_top;
  import iptp_pkg::*;

  // One parsed address as it leaves the block
  typedef struct {
    logic        status;
    logic        version;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } addr_result_t;

  // Running copy of both parses plus the queue of addresses still owed by the block
  class addr_scoreboard;
    addr_result_t pending_addrs[$];
    int unsigned  errors;

    bit          colon_seen;
    logic [9:0]  v4_val;
    int          v4_digits;
    int          v4_count;
    logic [31:0] v4_octets;
    bit          v4_bad;
    logic [15:0] groups[8];
    int          g_idx;
    logic [15:0] hex_val;
    int          hex_cnt;
    bit          gap_found;
    int          gap_pos;
    bit          colon_pend;
    bit          v6_done;
    bit          v6_bad;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      colon_seen = 0;
      v4_val     = '0;
      v4_digits  = 0;
      v4_count   = 0;
      v4_octets  = '0;
      v4_bad     = 0;
      foreach (groups[i]) groups[i] = '0;
      g_idx      = 0;
      hex_val    = '0;
      hex_cnt    = 0;
      gap_found  = 0;
      gap_pos    = 0;
      colon_pend = 0;
      v6_done    = 0;
      v6_bad     = 0;
    endfunction

    function int outstanding();
      return pending_addrs.size();
    endfunction

    // Hex digit value, or -1 for any other character
    function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    // Close one decimal octet
    function void close_octet();
      if (v4_digits == 0 || v4_val > OCTET_MAX || v4_count >= V4_OCTETS) begin
        v4_bad = 1;
        return;
      end
      v4_octets = {v4_octets[23:0], v4_val[7:0]};
      v4_count++;
      v4_val    = '0;
      v4_digits = 0;
    endfunction

    function void step_v4(logic [7:0] c);
      if (v4_bad) return;
      if (c == CHR_NUL || c == CHR_DOT) begin
        close_octet();
        if (c == CHR_NUL && !v4_bad && v4_count != V4_OCTETS) v4_bad = 1;
        return;
      end
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
        if (v4_digits >= V4_MAX_DIGITS) begin
          v4_bad = 1;
          return;
        end
        v4_val = 10'(v4_val * 10 + (c - CHR_ZERO));
        v4_digits++;
        return;
      end
      v4_bad = 1;
    endfunction

    // Store the open hex group, if any, and stop once all eight are in
    function void store_group();
      if (hex_cnt > 0 && g_idx < V6_GROUPS) begin
        groups[g_idx] = hex_val;
        g_idx++;
        hex_val = '0;
        hex_cnt = 0;
        if (g_idx >= V6_GROUPS) v6_done = 1;
      end
    endfunction

    function void step_v6(logic [7:0] c);
      int d;
      if (v6_done || v6_bad) return;
      if (c == CHR_COLON) begin
        if (colon_pend) begin
          store_group();
          if (!gap_found) begin
            gap_found  = 1;
            gap_pos    = g_idx;
            colon_pend = 0;
          end
        end else begin
          colon_pend = 1;
        end
        return;
      end
      if (colon_pend) begin
        colon_pend = 0;
        store_group();
        if (v6_done) return;
      end
      d = nibble_of(c);
      if (d < 0) begin
        v6_bad = 1;
        return;
      end
      if (hex_cnt < V6_HEX_DIGITS) begin
        hex_val = {hex_val[11:0], 4'(d)};
        hex_cnt++;
      end
    endfunction

    // Advance the parse by one accepted character; the terminator owes one result
    function void note_char(logic [7:0] c);
      addr_result_t r;
      logic [15:0]  g[8];
      int           shift;
      step_v4(c);
      if (c != CHR_NUL) begin
        if (c == CHR_COLON) colon_seen = 1;
        step_v6(c);
        return;
      end
      r.addr_high = '0;
      r.addr_low  = '0;
      if (colon_seen) begin
        r.version = 1'b1;
        r.status  = v6_bad;
        if (!v6_bad) begin
          if (!v6_done) begin
            colon_pend = 0;
            store_group();
          end
          g = groups;
          // Move the groups after the double colon to the tail
          if (gap_found && g_idx < V6_GROUPS) begin
            shift = V6_GROUPS - g_idx;
            for (int k = 0; k < 8; k++) begin
              if (k < gap_pos) g[k] = groups[k];
              else if (k < gap_pos + shift) g[k] = '0;
              else g[k] = groups[(k - shift) & 7];
            end
          end
          r.addr_high = {g[0], g[1], g[2], g[3]};
          r.addr_low  = {g[4], g[5], g[6], g[7]};
        end
      end else begin
        r.version = 1'b0;
        r.status  = v4_bad;
        if (!v4_bad) r.addr_low = {32'd0, v4_octets};
      end
      pending_addrs.push_back(r);
      clear_parse();
    endfunction

    function void check_result(logic st, logic ver, logic [63:0] hi, logic [63:0] lo);
      addr_result_t e;
      if (pending_addrs.size() == 0) begin
        $error("unexpected result: status=%0d version=%0d addr_high=%h addr_low=%h",
               st, ver, hi, lo);
        errors++;
        return;
      end
      e = pending_addrs.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (ver !== e.version) begin
        $error("version: expected %0d, actual %0d", e.version, ver);
        errors++;
      end
      if (hi !== e.addr_high) begin
        $error("addr_high: expected %h, actual %h", e.addr_high, hi);
        errors++;
      end
      if (lo !== e.addr_low) begin
        $error("addr_low: expected %h, actual %h", e.addr_low, lo);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  character = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        status;
  logic        version;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  addr_scoreboard board = new();
  logic [7:0]     text_q[$];
  int             burst_left = 0;
  int             counted = 0;
  bit             long_hold = 0;

  ip_address_text_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .character    (character),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .version      (version),
    .addr_high    (addr_high),
    .addr_low     (addr_low)
  );

  always #5 clk = ~clk;

  // Offer one character, idling between bursts, and hold it until taken
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    char_valid <= 1'b1;
    character  <= c;
    do @(posedge clk); while (char_stall);
    board.note_char(c);
    burst_left--;
  endtask

  // Send the built text plus its terminator
  task automatic send_text(input bit counts);
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i]);
    send_char(CHR_NUL);
    if (counts) counted += text_q.size() + 1;
    text_q.delete();
  endtask

  // Pause until every owed address has come out, then let the block settle
  task automatic drain();
    char_valid <= 1'b0;
    burst_left = 0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    string lo_digits;
    string up_digits;
    lo_digits = "0123456789abcdef";
    up_digits = "0123456789ABCDEF";
    return $urandom_range(0, 1) ? up_digits[v] : lo_digits[v];
  endfunction

  // Any nonzero byte that is neither a decimal digit, a dot nor a colon
  function automatic logic [7:0] v4_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= CHR_ZERO && c <= CHR_NINE) || c == CHR_DOT || c == CHR_COLON);
    return c;
  endfunction

  // Any nonzero byte that is neither a hex digit nor a colon
  function automatic logic [7:0] v6_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (board.nibble_of(c) >= 0 || c == CHR_COLON);
    return c;
  endfunction

  function automatic void add_octet();
    int    v;
    int    w;
    string s;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 255;
      default: v = $urandom_range(0, 255);
    endcase
    s = $sformatf("%0d", v);
    // Pad with leading zeros now and then
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom_range(1, 3);
      while (s.len() < w) s = {"0", s};
    end
    add_str(s);
  endfunction

  // Dotted quad; kind 0 is well formed, others break it in one way
  function automatic void make_v4(int kind);
    int n;
    int bad_at;
    n      = (kind == 3) ? 3 : (kind == 4) ? 5 : 4;
    bad_at = $urandom_range(0, n - 1);
    if (kind == 7) add_str(".");
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_str(".");
      if (i == bad_at && kind == 2) begin
        // leave the octet empty
      end else if (i == bad_at && kind == 1) begin
        add_str($sformatf("%0d", $urandom_range(256, 999)));
      end else if (i == bad_at && kind == 8) begin
        add_str($sformatf("%04d", $urandom_range(0, 255)));
      end else begin
        add_octet();
      end
      if (i == bad_at && kind == 5) text_q.push_back(v4_junk());
    end
    if (kind == 6) add_str(".");
  endfunction

  function automatic void add_group(int ndig);
    for (int i = 0; i < ndig; i++) begin
      text_q.push_back(($urandom_range(0, 5) == 0) ? hex_char(15)
                                                   : hex_char($urandom_range(0, 15)));
    end
  endfunction

  // Hex groups with or without a double colon; kind 0 is well formed
  function automatic void make_v6(int kind);
    int n;
    int p;
    int long_at;
    bit squeeze;
    squeeze = (kind == 3) || ($urandom_range(0, 1) == 1);
    if (kind == 4) squeeze = 0;
    if (squeeze) begin
      n = $urandom_range(0, 7);
      p = $urandom_range(0, n);
    end else begin
      n = 8;
      p = -1;
    end
    long_at = $urandom_range(0, 7);
    if (kind == 2) add_str($urandom_range(0, 1) ? ":" : ":1:");
    for (int i = 0; i < n; i++) begin
      if (i == p) add_str("::");
      else if (i > 0) add_str(":");
      add_group((kind == 1 && (i == long_at || i == n - 1)) ? $urandom_range(5, 7)
                                                             : $urandom_range(1, 4));
    end
    if (p == n) add_str("::");
    case (kind)
      3: begin
        add_str("::");
        add_group($urandom_range(1, 4));
      end
      4: begin
        // Tail after eight groups, junk included
        add_str(":");
        for (int i = $urandom_range(1, 6); i > 0; i--) text_q.push_back(8'($urandom_range(1, 255)));
      end
      5: text_q.insert($urandom_range(0, text_q.size()), v6_junk());
      6: begin
        add_str(":::");
        add_group($urandom_range(1, 4));
      end
      7: add_str(":");
      default: ;
    endcase
  endfunction

  // Random bytes with dots and colons sprinkled in
  function automatic void make_noise();
    for (int i = $urandom_range(0, 12); i > 0; i--) begin
      case ($urandom_range(0, 5))
        0:       text_q.push_back(CHR_COLON);
        1:       text_q.push_back(CHR_DOT);
        default: text_q.push_back(8'($urandom_range(1, 255)));
      endcase
    end
  endfunction

  // Receiver: check each taken result, stall on a changing pattern
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit hold_taken;
    bit stall_next;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        board.check_result(status, version, addr_high, addr_low);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (long_hold && !hold_taken) begin
        hold_taken = 1;
        hold_left  = 300;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 2) == 0);
          2:       stall_next = (mode_left % 4 == 0);
          default: stall_next = ($urandom_range(0, 3) != 0);
        endcase
      end
      result_stall <= stall_next;
    end
  end

  // Stimulus: directed strings first, then random ones
  initial begin
    string directed_cases[] = '{
      "", "0.0.0.0", "255.255.255.255", "256.1.1.1", "1.2.3", "1.2.3.4.5",
      "1..2.3", "0001.2.3.4", "1.2.3.4.", "1.2.a.4", "::", "::1",
      "ffff:FFFF:0:0:0:0:0:ffff", "1:2:3:4:5:6:7:8", "12345::1", ":1:2",
      "1::2::3", "1:2:3:4:5:6:7:8:zz9", "1:2:g::", "1:::2", "fe80::1:2",
      "a:b:c:d:e:f:1:2:3"
    };
    int pick;
    bit hold_done;
    bit pause_done;
    hold_done  = 0;
    pause_done = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cases[i]) begin
      add_str(directed_cases[i]);
      send_text(1'b1);
    end
    drain();

    while (counted < 1650) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        make_v4(0);
        send_text(1'b1);
      end else if (pick < 50) begin
        make_v4($urandom_range(1, 8));
        send_text(1'b1);
      end else if (pick < 80) begin
        make_v6(0);
        send_text(1'b1);
      end else if (pick < 92) begin
        make_v6($urandom_range(1, 7));
        send_text(1'b1);
      end else begin
        make_noise();
        send_text(1'b0);
      end
      // Hold the output off while strings keep coming, so the block backs up
      if (!hold_done && counted > 500) begin
        hold_done = 1;
        long_hold = 1;
        repeat (6) begin
          make_v4(0);
          send_text(1'b1);
        end
      end
      if (!pause_done && counted > 1100) begin
        pause_done = 1;
        drain();
      end
    end
    drain();

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
